### design/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher block.
`timescale 1ns / 1ps
`default_nettype none
package rc4_pkg;

    localparam int BYTE_W            = 8;
    localparam int TABLE_DEPTH       = 256;
    localparam int TABLE_AW          = $clog2(TABLE_DEPTH);
    localparam int KEY_WORDS         = 4;
    localparam int KEY_WORD_W        = 64;
    localparam int KEY_BYTES         = KEY_WORDS * KEY_WORD_W / BYTE_W;
    localparam int KEY_POS_W         = $clog2(KEY_BYTES);
    localparam int KEY_LEN_W         = 6;
    localparam int KEY_MAX_BYTES_DEF = 32;
    localparam int APB_AW            = 6;
    localparam int APB_DW            = 64;
    localparam int REG_IDX_W         = 3;

    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD0  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD1  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD2  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD3  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH = 3'd4;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_MIX_RD_N,
        ST_MIX_RD_J,
        ST_MIX_WR_N,
        ST_MIX_WR_J,
        ST_RD_I,
        ST_RD_J,
        ST_SWAP1,
        ST_SWAP2
    } t_state;

    typedef struct packed {
        logic [KEY_BYTES-1:0][BYTE_W-1:0] key;
        logic [KEY_LEN_W-1:0]             key_len;
    } t_key_cfg;

    typedef struct packed {
        logic                we;
        logic [TABLE_AW-1:0] waddr;
        logic [BYTE_W-1:0]   wdata;
        logic                re;
        logic [TABLE_AW-1:0] raddr;
    } t_ram_req;

endpackage
`default_nettype wire

### design/rc4_stream_cipher_top.sv
// Top level of the RC4 stream cipher: key registers, sequencer and table RAM.
// A byte accepted in idle passes ST_RD_J, ST_SWAP1 and ST_SWAP2 (held while the
// output slot is full) to a registered result at o_data_out; one that needs the
// key schedule first runs fill and mix over all 256 table entries. New bytes are
// taken only in idle, after dependent reads S[i], S[j], S[S[i]+S[j]] on one port.
// Reset is synchronous, active low: indices, schedule flag and key registers clear,
// key length returns to 32; table contents stay undefined until the first schedule.
`timescale 1ns / 1ps
`default_nettype none
module rc4_stream_cipher_top
    import rc4_pkg::*;
#(
    parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [BYTE_W-1:0] i_data_in,
    input  wire logic              i_start_msg,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [BYTE_W-1:0] o_data_out
);

    logic [KEY_WORDS-1:0][KEY_WORD_W-1:0] r_key;
    logic [KEY_LEN_W-1:0]                 r_key_len;
    logic [REG_IDX_W-1:0]                 reg_idx;
    logic                                 wr_en;
    t_key_cfg                             cfg;
    t_ram_req                             ram_req;
    logic [BYTE_W-1:0]                    rd_data;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_key_len <= KEY_LEN_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_KEY_WORD0:  r_key[0]  <= pwdata;
                REG_KEY_WORD1:  r_key[1]  <= pwdata;
                REG_KEY_WORD2:  r_key[2]  <= pwdata;
                REG_KEY_WORD3:  r_key[3]  <= pwdata;
                REG_KEY_LENGTH: r_key_len <= pwdata[KEY_LEN_W-1:0];
                default: begin
                    // drop writes to unmapped addresses
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_KEY_WORD0:  prdata = r_key[0];
            REG_KEY_WORD1:  prdata = r_key[1];
            REG_KEY_WORD2:  prdata = r_key[2];
            REG_KEY_WORD3:  prdata = r_key[3];
            REG_KEY_LENGTH: prdata = APB_DW'(r_key_len);
            default:        prdata = '0;
        endcase
    end

    assign cfg = '{key: r_key, key_len: r_key_len};

    rc4_seq #(
        .KEY_MAX_BYTES(KEY_MAX_BYTES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_in   (i_data_in),
        .i_start_msg (i_start_msg),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data_out  (o_data_out),
        .o_ram       (ram_req),
        .i_rd_data   (rd_data)
    );

    rc4_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rd_data)
    );

endmodule
`default_nettype wire

### design/rc4_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### design/rc4_seq.sv
// Sequencer for key schedule and keystream generation over one table RAM.
`timescale 1ns / 1ps
`default_nettype none
module rc4_seq
    import rc4_pkg::*;
#(
    parameter int KEY_MAX_BYTES = KEY_MAX_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_key_cfg          i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [BYTE_W-1:0] i_data_in,
    input  wire logic              i_start_msg,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [BYTE_W-1:0] o_data_out,
    output t_ram_req               o_ram,
    input  wire logic [BYTE_W-1:0] i_rd_data
);

    localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(KEY_MAX_BYTES);

    t_state                 r_state, n_state;
    logic [TABLE_AW-1:0]    r_i, n_i;
    logic [TABLE_AW-1:0]    r_j, n_j;
    logic [BYTE_W-1:0]      r_a, n_a;
    logic [BYTE_W-1:0]      r_b, n_b;
    logic [TABLE_AW-1:0]    r_n, n_n;
    logic [TABLE_AW-1:0]    r_acc, n_acc;
    logic [KEY_POS_W-1:0]   r_pos, n_pos;
    logic [BYTE_W-1:0]      r_data, n_data;
    logic                   r_sched, n_sched;
    logic                   r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]      r_out, n_out;

    logic [KEY_LEN_W-1:0]   eff_len;
    logic [KEY_LEN_W-1:0]   pos_inc;
    logic [TABLE_AW-1:0]    ab_sum;
    logic [BYTE_W-1:0]      ks;
    logic                   slot_free;

    always_comb begin
        eff_len = i_cfg.key_len;
        if (eff_len == '0) begin
            eff_len = KEY_LEN_W'(1);
        end else if (eff_len > MAX_LEN) begin
            eff_len = MAX_LEN;
        end
    end

    assign pos_inc   = KEY_LEN_W'({1'b0, r_pos}) + KEY_LEN_W'(1);
    assign ab_sum    = TABLE_AW'(r_a + r_b);
    assign slot_free = !r_out_valid || !i_out_stall;

    // Post-swap value at a+b: swapped entries come from registers, others from RAM.
    always_comb begin
        priority if (ab_sum == r_i) begin
            ks = r_b;
        end else if (ab_sum == r_j) begin
            ks = r_a;
        end else begin
            ks = i_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_sched     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_sched     <= n_sched;
            r_out_valid <= n_out_valid;
        end
        r_a    <= n_a;
        r_b    <= n_b;
        r_n    <= n_n;
        r_acc  <= n_acc;
        r_pos  <= n_pos;
        r_data <= n_data;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_a         = r_a;
        n_b         = r_b;
        n_n         = r_n;
        n_acc       = r_acc;
        n_pos       = r_pos;
        n_data      = r_data;
        n_sched     = r_sched;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_ram       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_data = i_data_in;
                    if (i_start_msg || !r_sched) begin
                        n_n     = '0;
                        n_state = ST_FILL;
                    end else begin
                        // Fetch S[i+1] in the accept cycle.
                        o_ram.re    = 1'b1;
                        o_ram.raddr = TABLE_AW'(r_i + 1'b1);
                        n_i         = TABLE_AW'(r_i + 1'b1);
                        n_state     = ST_RD_J;
                    end
                end
            end
            ST_FILL: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_n;
                o_ram.wdata = r_n;
                n_n         = TABLE_AW'(r_n + 1'b1);
                if (r_n == '1) begin
                    n_acc   = '0;
                    n_pos   = '0;
                    n_state = ST_MIX_RD_N;
                end
            end
            ST_MIX_RD_N: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = r_n;
                n_state     = ST_MIX_RD_J;
            end
            ST_MIX_RD_J: begin
                n_a         = i_rd_data;
                n_acc       = TABLE_AW'(r_acc + i_rd_data + i_cfg.key[r_pos]);
                o_ram.re    = 1'b1;
                o_ram.raddr = n_acc;
                n_state     = ST_MIX_WR_N;
            end
            ST_MIX_WR_N: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_n;
                o_ram.wdata = i_rd_data;
                n_state     = ST_MIX_WR_J;
            end
            ST_MIX_WR_J: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_acc;
                o_ram.wdata = r_a;
                n_n         = TABLE_AW'(r_n + 1'b1);
                if (pos_inc >= eff_len) begin
                    n_pos = '0;
                end else begin
                    n_pos = KEY_POS_W'(pos_inc);
                end
                if (r_n == '1) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_sched = 1'b1;
                    n_state = ST_RD_I;
                end else begin
                    n_state = ST_MIX_RD_N;
                end
            end
            ST_RD_I: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = TABLE_AW'(r_i + 1'b1);
                n_i         = TABLE_AW'(r_i + 1'b1);
                n_state     = ST_RD_J;
            end
            ST_RD_J: begin
                n_a         = i_rd_data;
                n_j         = TABLE_AW'(r_j + i_rd_data);
                o_ram.re    = 1'b1;
                o_ram.raddr = n_j;
                n_state     = ST_SWAP1;
            end
            ST_SWAP1: begin
                n_b         = i_rd_data;
                o_ram.we    = 1'b1;
                o_ram.waddr = r_i;
                o_ram.wdata = i_rd_data;
                o_ram.re    = 1'b1;
                o_ram.raddr = TABLE_AW'(r_a + i_rd_data);
                n_state     = ST_SWAP2;
            end
            ST_SWAP2: begin
                // Hold here while the output slot is full; the repeated write is harmless.
                o_ram.we    = 1'b1;
                o_ram.waddr = r_j;
                o_ram.wdata = r_a;
                if (slot_free) begin
                    n_out       = r_data ^ ks;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out;

endmodule
`default_nettype wire

### design/rc4_chk.sv
// Port-level checker for the RC4 stream cipher top level, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module rc4_chk
    import rc4_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [BYTE_W-1:0] o_data_out
);

    // A held result keeps its value until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_data_out)))
        else $error("result changed or dropped while stalled");

    // Block goes busy right after taking a request.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block not busy after accepting a request");

    // A new result appears only at the end of a busy stretch.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work in progress");

    // Reset leaves the block idle with no pending result.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after reset");

endmodule

bind rc4_stream_cipher_top rc4_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_data_out  (o_data_out)
);
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
// Testbench for the RC4 stream cipher: APB key setup, byte traffic, checked by a local RC4.
module testbench;
    import rc4_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 4;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RESULT_SETTLE = 16;
    localparam int HOLD_CYCLES   = 400;

    // Register slots past the key length are unmapped
    localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] in_data  = '0;
    logic              in_start = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [BYTE_W-1:0] out_data;

    // Shadow of the key registers and of the cipher state
    logic [KEY_WORD_W-1:0] key_shadow [KEY_WORDS];
    logic [KEY_LEN_W-1:0]  key_len_shadow;
    logic [BYTE_W-1:0]     sbox [TABLE_DEPTH];
    logic [BYTE_W-1:0]     sbox_i;
    logic [BYTE_W-1:0]     sbox_j;
    bit                    sbox_keyed;

    logic [BYTE_W-1:0] pending_bytes [$];
    int mismatches        = 0;
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int hold_request      = 0;
    int cycle_count       = 0;

    rc4_stream_cipher_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_data_in  (in_data),
        .i_start_msg(in_start),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_data_out (out_data)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Advance the cipher by one byte; rerun the key schedule on start or when never keyed
    function automatic logic [BYTE_W-1:0] rc4_next_byte(input logic [BYTE_W-1:0] data,
                                                         input logic start);
        int n;
        int len;
        int kpos;
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] tmp;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] ks_idx;
        if (start || !sbox_keyed) begin
            len = int'(key_len_shadow);
            if (len == 0) len = 1;
            if (len > KEY_MAX_BYTES_DEF) len = KEY_MAX_BYTES_DEF;
            for (n = 0; n < TABLE_DEPTH; n++) sbox[n[TABLE_AW-1:0]] = BYTE_W'(n);
            acc  = '0;
            kpos = 0;
            for (n = 0; n < TABLE_DEPTH; n++) begin
                acc = acc + sbox[n[TABLE_AW-1:0]]
                    + key_shadow[kpos[4:3]][(kpos % 8) * 8 +: 8];
                tmp = sbox[n[TABLE_AW-1:0]];
                sbox[n[TABLE_AW-1:0]] = sbox[acc];
                sbox[acc] = tmp;
                kpos = (kpos + 1 >= len) ? 0 : kpos + 1;
            end
            sbox_i     = '0;
            sbox_j     = '0;
            sbox_keyed = 1'b1;
        end
        sbox_i = sbox_i + 8'd1;
        sbox_j = sbox_j + sbox[sbox_i];
        a = sbox[sbox_i];
        b = sbox[sbox_j];
        sbox[sbox_i] = b;
        sbox[sbox_j] = a;
        ks_idx = a + b;
        return data ^ sbox[ks_idx];
    endfunction

    // Offer one request after a random gap and predict its output on acceptance
    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic start);
        int gap;
        logic [BYTE_W-1:0] predicted;
        gap = 0;
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
            gap = $urandom_range(1, 5);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= data;
        in_start <= start;
        do @(posedge clk); while (in_stall);
        predicted     = rc4_next_byte(data, start);
        pending_bytes = {pending_bytes, predicted};
    endtask

    // Drop valid and hold until every predicted byte has come out
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_KEY_WORD0, REG_KEY_WORD1, REG_KEY_WORD2, REG_KEY_WORD3: begin
                key_shadow[idx[1:0]] = value;
            end
            REG_KEY_LENGTH: begin
                key_len_shadow = value[KEY_LEN_W-1:0];
            end
            default: begin
            end
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_registers();
        int r;
        logic [APB_DW-1:0] want;
        for (r = REG_KEY_WORD0; r <= REG_KEY_LENGTH; r++) begin
            @(negedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {r[REG_IDX_W-1:0], 3'b000};
            @(negedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            want = (r == REG_KEY_LENGTH) ? APB_DW'(key_len_shadow) : key_shadow[r[1:0]];
            if (prdata !== want)
                report_mismatch($sformatf("register %0d reads %h, want %h", r, prdata, want));
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic load_random_key();
        int w;
        int pick;
        logic [APB_DW-1:0] word;
        for (w = 0; w < KEY_WORDS; w++) begin
            pick = $urandom_range(9);
            if (pick == 0) word = '0;
            else if (pick == 1) word = '1;
            else word = {$urandom, $urandom};
            apb_write(REG_IDX_W'(w), word);
        end
        pick = $urandom_range(3);
        if (pick == 0) apb_write(REG_KEY_LENGTH, APB_DW'(1));
        else if (pick == 1) apb_write(REG_KEY_LENGTH, APB_DW'(KEY_MAX_BYTES_DEF));
        else apb_write(REG_KEY_LENGTH, APB_DW'($urandom_range(0, 63)));
        check_registers();
    endtask

    // Receiver: honor a requested hold-off first, else stall at random
    always @(negedge clk) begin : receiver
        int hold_left;
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (receiver_idle_pct > 0 && $urandom_range(99) < receiver_idle_pct) begin
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin : output_check
        logic [BYTE_W-1:0] want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("output byte %h with nothing pending", out_data));
            end else begin
                want = pending_bytes.pop_front();
                if (out_data !== want)
                    report_mismatch($sformatf("data_out %h, want %h", out_data, want));
            end
        end
    end

    // First bytes after reset key the table without start_msg
    task automatic test_reset_state();
        check_registers();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);
    endtask

    // Lengths of one, maximum, zero, beyond maximum and thirteen, then an all-ones key
    task automatic test_key_lengths();
        int w;
        int k;
        int lens [6];
        lens = '{1, 32, 0, 63, 33, 13};
        wait_drained();
        for (w = 0; w < KEY_WORDS; w++)
            apb_write(REG_IDX_W'(w), 64'h0807060504030201 + w * 64'h0808080808080808);
        for (k = 0; k < 6; k++) begin
            wait_drained();
            apb_write(REG_KEY_LENGTH, APB_DW'(lens[k[2:0]]));
            send_byte(8'h00, 1'b1);
            send_byte(8'hFF, 1'b0);
        end
        wait_drained();
        for (w = 0; w < KEY_WORDS; w++) apb_write(REG_IDX_W'(w), '1);
        apb_write(REG_KEY_LENGTH, APB_DW'(KEY_MAX_BYTES_DEF));
        check_registers();
        send_byte(8'h81, 1'b1);
    endtask

    // A new key must not disturb the running message until the next start
    task automatic test_key_change_mid_message();
        wait_drained();
        apb_write(REG_KEY_LENGTH, APB_DW'(16));
        send_byte(8'h3C, 1'b1);
        send_byte(8'hC3, 1'b0);
        wait_drained();
        apb_write(REG_KEY_WORD0, 64'h0123_4567_89AB_CDEF);
        apb_write(REG_KEY_LENGTH, APB_DW'(5));
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h0F, 1'b1);
    endtask

    // Writes to unmapped slots drop; key length keeps only its low bits
    task automatic test_unmapped_registers();
        wait_drained();
        apb_write(REG_SPARE_FIRST, '1);
        apb_write(REG_SPARE_LAST, 64'h5A5A_5A5A_5A5A_5A5A);
        apb_write(REG_KEY_LENGTH, 64'hFFFF_FFFF_FFFF_FFC7);
        check_registers();
        send_byte(8'h5A, 1'b1);
    endtask

    task automatic test_repeated_starts();
        send_byte(8'h01, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'h7E, 1'b1);
    endtask

    // Hold the output long enough that the block backs up into its input
    task automatic test_receiver_hold();
        int k;
        wait_drained();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        send_byte(BYTE_W'($urandom_range(255)), 1'b1);
        wait_drained();
        hold_request = HOLD_CYCLES;
        for (k = 0; k < 60; k++) send_byte(BYTE_W'($urandom_range(255)), 1'b0);
        wait_drained();
    endtask

    // Messages with random content; a few run past the index wrap, some lack a start
    task automatic test_random_traffic(input int s_pct, input int r_pct, input int n_bytes);
        int sent;
        int msg_len;
        int pick;
        int k;
        logic start;
        wait_drained();
        load_random_key();
        sender_idle_pct   = s_pct;
        receiver_idle_pct = r_pct;
        sent = 0;
        while (sent < n_bytes) begin
            if ($urandom_range(99) < 15) begin
                wait_drained();
                load_random_key();
            end
            pick = $urandom_range(99);
            if (pick < 80) msg_len = $urandom_range(1, 24);
            else if (pick < 95) msg_len = $urandom_range(25, 100);
            else msg_len = $urandom_range(257, 400);
            for (k = 0; k < msg_len; k++) begin
                if (k == 0) start = ($urandom_range(99) >= 10);
                else start = ($urandom_range(99) < 3);
                send_byte(BYTE_W'($urandom_range(255)), start);
            end
            sent += msg_len;
        end
    endtask

    initial begin
        key_shadow     = '{default: '0};
        key_len_shadow = KEY_LEN_RESET;
        sbox_i         = '0;
        sbox_j         = '0;
        sbox_keyed     = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        sender_idle_pct   = 7;
        receiver_idle_pct = 54;
        test_reset_state();
        test_key_lengths();
        test_key_change_mid_message();
        test_unmapped_registers();
        test_repeated_starts();
        test_random_traffic(7, 54, 520);
        test_random_traffic(54, 7, 520);
        test_receiver_hold();
        test_random_traffic(0, 0, 500);

        wait_drained();
        repeat (RESULT_SETTLE) @(posedge clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
